FILE: sv/pfdc_pkg.sv
// shared types, codes and square geometry helpers for the playfair cipher
`default_nettype none

package pfdc_pkg;

  // field widths
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned RC_W     = 3;

  // square and alphabet sizes
  localparam int unsigned CELLS   = 25;
  localparam int unsigned LETTERS = 26;

  // letter codes
  localparam logic [LETTER_W-1:0] CODE_I    = 5'd8;
  localparam logic [LETTER_W-1:0] CODE_J    = 5'd9;
  localparam logic [LETTER_W-1:0] CODE_Z    = 5'd25;
  localparam logic [LETTER_W-1:0] CELLS_CNT = 5'd25;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_KEY    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ENC    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEC    = 3'd4;

  // cell indexes of the two result letters of one pair
  typedef struct packed {
    logic [LETTER_W-1:0] x_idx;
    logic [LETTER_W-1:0] y_idx;
  } pair_idx_t;

  // clamp codes above z to z and fold j into i
  function automatic logic [LETTER_W-1:0] norm_letter(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] c;
    c = (v > CODE_Z) ? CODE_Z : v;
    if (c == CODE_J) c = CODE_I;
    return c;
  endfunction

  // row of a cell index 0..24
  function automatic logic [RC_W-1:0] pos_row(input logic [LETTER_W-1:0] p);
    logic [RC_W-1:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // column of a cell index 0..24
  function automatic logic [RC_W-1:0] pos_col(input logic [LETTER_W-1:0] p);
    logic [RC_W-1:0]     r;
    logic [LETTER_W-1:0] base;
    logic [LETTER_W-1:0] diff;
    r    = pos_row(p);
    base = ({2'b00, r} << 2) + {2'b00, r};
    diff = p - base;
    return diff[RC_W-1:0];
  endfunction

  // row * 5 + col
  function automatic logic [LETTER_W-1:0] cell_index(input logic [RC_W-1:0] r,
                                                     input logic [RC_W-1:0] c);
    logic [LETTER_W-1:0] v;
    v = ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    return v;
  endfunction

  // one step around a row or column, forward to encrypt, back to decrypt
  function automatic logic [RC_W-1:0] step_rc(input logic [RC_W-1:0] v, input logic dec);
    logic [RC_W-1:0] s;
    if (dec) s = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else     s = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pfdc_geom.sv
// pair geometry: from the two letter positions to the two result cells
`default_nettype none

module pfdc_geom (
  input  wire logic [pfdc_pkg::LETTER_W-1:0] pa,
  input  wire logic [pfdc_pkg::LETTER_W-1:0] pb,
  input  wire logic                          dec,
  output pfdc_pkg::pair_idx_t                idx
);

  logic [pfdc_pkg::RC_W-1:0] ra, ca, rb, cb;

  // split positions into row and column
  always_comb begin
    ra = pfdc_pkg::pos_row(pa);
    ca = pfdc_pkg::pos_col(pa);
    rb = pfdc_pkg::pos_row(pb);
    cb = pfdc_pkg::pos_col(pb);
  end

  // same column, same row, or rectangle corners
  always_comb begin
    if (ca == cb) begin
      idx.x_idx = pfdc_pkg::cell_index(pfdc_pkg::step_rc(ra, dec), ca);
      idx.y_idx = pfdc_pkg::cell_index(pfdc_pkg::step_rc(rb, dec), cb);
    end else if (ra == rb) begin
      idx.x_idx = pfdc_pkg::cell_index(ra, pfdc_pkg::step_rc(ca, dec));
      idx.y_idx = pfdc_pkg::cell_index(rb, pfdc_pkg::step_rc(cb, dec));
    end else begin
      idx.x_idx = pfdc_pkg::cell_index(ra, cb);
      idx.y_idx = pfdc_pkg::cell_index(rb, ca);
    end
  end

endmodule

`default_nettype wire

FILE: sv/playfair_digraph_cipher.sv
// Playfair digraph cipher: key square in memory, pair transform, result stage
//
// Input channel (in_valid/in_ready) carries one action with a letter and a
// last flag; the result channel (out_valid/out_ready) carries cipher or plain
// letters, with out_end_of_run marking the final letter caused by a transaction.
// A key letter, a clear or a letter that is only held leaves the sequencer idle. A
// finish sweeps the alphabet, one letter a cycle, writing the square and position
// memories. A message letter that completes a pair shows its results after two reads
// of the position memory, then two of the square memory, each read registered; the
// next transaction is taken once the last result sits in the output register. A
// doubled encrypt pair runs that pass twice, giving four results.
// One transaction is in work at a time; in_ready is high when the
// sequencer is idle, while the last result may still sit in the output register.
// When the receiver stalls, the sequencer holds its square read data and waits.
// Reset clears the placed flags, fill count and held letter; the square
// memories need no clearing, since unplaced letters and unfilled cells are masked.
`default_nettype none

module playfair_digraph_cipher (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [pfdc_pkg::ACTION_W-1:0] in_action,
  input  wire logic [pfdc_pkg::LETTER_W-1:0] in_letter,
  input  wire logic                          in_last,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [pfdc_pkg::LETTER_W-1:0] out_letter,
  output      logic                          out_end_of_run
);

  localparam int unsigned LW = pfdc_pkg::LETTER_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FILL = 7'b0000010,
    S_RPA  = 7'b0000100,
    S_RPB  = 7'b0001000,
    S_RCX  = 7'b0010000,
    S_RCY  = 7'b0100000,
    S_OUTY = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // key square and letter position memories
  logic [LW-1:0] cell_mem [pfdc_pkg::CELLS];
  logic [LW-1:0] pos_mem  [pfdc_pkg::LETTERS];
  logic [LW-1:0] cell_q_r, pos_q_r;

  logic [pfdc_pkg::LETTERS-1:0] placed_r, placed_nxt;
  logic [LW-1:0] filled_r, filled_nxt;
  logic [LW-1:0] held_r, held_nxt;
  logic          holding_r, holding_nxt;
  logic [LW-1:0] fill_cnt_r, fill_cnt_nxt;

  // pair operands and intermediate results
  logic [LW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic          dec_r, dec_nxt;
  logic          rep_r, rep_nxt;
  logic [LW-1:0] pa_r, pa_nxt;
  logic [LW-1:0] yidx_r, yidx_nxt;
  logic          xok_r, xok_nxt, yok_r, yok_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_letter_r, out_letter_nxt;
  logic          out_end_r, out_end_nxt;

  logic          out_free;
  logic [LW-1:0] cin;
  logic [LW-1:0] pb;
  logic          place_req, place_ok;
  logic [LW-1:0] place_letter;
  logic          pos_re, cell_re;
  logic [LW-1:0] pos_raddr, cell_raddr;
  pfdc_pkg::pair_idx_t pidx;

  assign cin      = pfdc_pkg::norm_letter(in_letter);
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign pb       = placed_r[b_r] ? pos_q_r : '0;

  pfdc_geom u_geom (
    .pa  (pa_r),
    .pb  (pb),
    .dec (dec_r),
    .idx (pidx)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    placed_nxt     = placed_r;
    filled_nxt     = filled_r;
    held_nxt       = held_r;
    holding_nxt    = holding_r;
    fill_cnt_nxt   = fill_cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    dec_nxt        = dec_r;
    rep_nxt        = rep_r;
    pa_nxt         = pa_r;
    yidx_nxt       = yidx_r;
    xok_nxt        = xok_r;
    yok_nxt        = yok_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_letter_nxt = out_letter_r;
    out_end_nxt    = out_end_r;
    place_req      = 1'b0;
    place_letter   = cin;
    pos_re         = 1'b0;
    cell_re        = 1'b0;
    pos_raddr      = a_r;
    cell_raddr     = yidx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            pfdc_pkg::ACT_CLEAR: begin
              placed_nxt  = '0;
              filled_nxt  = '0;
              held_nxt    = '0;
              holding_nxt = 1'b0;
            end
            pfdc_pkg::ACT_KEY: begin
              place_req = 1'b1;
            end
            pfdc_pkg::ACT_FINISH: begin
              fill_cnt_nxt = '0;
              state_nxt    = S_FILL;
            end
            pfdc_pkg::ACT_ENC: begin
              dec_nxt = 1'b0;
              if (holding_r) begin
                holding_nxt = 1'b0;
                a_nxt       = held_r;
                b_nxt       = (held_r == cin) ? pfdc_pkg::CODE_Z : cin;
                rep_nxt     = (held_r == cin);
                state_nxt   = S_RPA;
              end else if (in_last) begin
                a_nxt     = cin;
                b_nxt     = pfdc_pkg::CODE_Z;
                rep_nxt   = 1'b0;
                state_nxt = S_RPA;
              end else begin
                held_nxt    = cin;
                holding_nxt = 1'b1;
              end
            end
            pfdc_pkg::ACT_DEC: begin
              dec_nxt = 1'b1;
              rep_nxt = 1'b0;
              if (holding_r) begin
                holding_nxt = 1'b0;
                a_nxt       = held_r;
                b_nxt       = cin;
                state_nxt   = S_RPA;
              end else if (!in_last) begin
                held_nxt    = cin;
                holding_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        // place the rest of the alphabet, skipping j
        place_req    = (fill_cnt_r != pfdc_pkg::CODE_J);
        place_letter = fill_cnt_r;
        if (fill_cnt_r == pfdc_pkg::CODE_Z) state_nxt = S_IDLE;
        else fill_cnt_nxt = fill_cnt_r + 5'd1;
      end
      S_RPA: begin
        pos_re    = 1'b1;
        pos_raddr = a_r;
        state_nxt = S_RPB;
      end
      S_RPB: begin
        pos_re    = 1'b1;
        pos_raddr = b_r;
        pa_nxt    = placed_r[a_r] ? pos_q_r : '0;
        state_nxt = S_RCX;
      end
      S_RCX: begin
        cell_re    = 1'b1;
        cell_raddr = pidx.x_idx;
        yidx_nxt   = pidx.y_idx;
        xok_nxt    = (pidx.x_idx < filled_r);
        yok_nxt    = (pidx.y_idx < filled_r);
        state_nxt  = S_RCY;
      end
      S_RCY: begin
        // first letter out, second cell read in the same cycle
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = xok_r ? cell_q_r : '0;
          out_end_nxt    = 1'b0;
          cell_re        = 1'b1;
          cell_raddr     = yidx_r;
          state_nxt      = S_OUTY;
        end
      end
      S_OUTY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = yok_r ? cell_q_r : '0;
          out_end_nxt    = !rep_r;
          if (rep_r) begin
            rep_nxt   = 1'b0;
            state_nxt = S_RPA;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // key placement into the next free cell
    place_ok = place_req && (filled_r < pfdc_pkg::CELLS_CNT) && !placed_r[place_letter];
    if (place_ok) begin
      placed_nxt[place_letter] = 1'b1;
      filled_nxt               = filled_r + 5'd1;
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (place_ok) begin
      cell_mem[filled_r]    <= place_letter;
      pos_mem[place_letter] <= filled_r;
    end
    if (pos_re) pos_q_r <= pos_mem[pos_raddr];
    if (cell_re) cell_q_r <= cell_mem[cell_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      placed_r    <= '0;
      filled_r    <= '0;
      held_r      <= '0;
      holding_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      placed_r    <= placed_nxt;
      filled_r    <= filled_nxt;
      held_r      <= held_nxt;
      holding_r   <= holding_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fill_cnt_r   <= fill_cnt_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    dec_r        <= dec_nxt;
    rep_r        <= rep_nxt;
    pa_r         <= pa_nxt;
    yidx_r       <= yidx_nxt;
    xok_r        <= xok_nxt;
    yok_r        <= yok_nxt;
    out_letter_r <= out_letter_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_letter     = out_letter_r;
  assign out_end_of_run = out_end_r;

  // every filled cell holds exactly one placed letter
  a_placed_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(placed_r) == int'(filled_r))
    else $error("placed flags disagree with fill count");

  // j never enters the square
  a_no_j: assert property (@(posedge clk) disable iff (!rst_n)
    !placed_r[pfdc_pkg::CODE_J])
    else $error("letter j placed in square");

  // no letter is held while a pair is in work
  a_no_hold_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RPA || state_r == S_RPB || state_r == S_RCX ||
     state_r == S_RCY || state_r == S_OUTY) |-> !holding_r)
    else $error("first letter held during pair transform");

endmodule

`default_nettype wire

FILE: tb/sv/playfair_digraph_cipher_tb.sv
// testbench for the playfair digraph cipher: directed and random streams
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PRINT_CAP      = 40;
  localparam int SIDE           = 5;

  // one expected cipher or plain letter
  typedef struct {
    logic [pfdc_pkg::LETTER_W-1:0] letter;
    logic                          eor;
  } cipher_letter_t;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [pfdc_pkg::ACTION_W-1:0] in_action      = pfdc_pkg::ACT_CLEAR;
  logic [pfdc_pkg::LETTER_W-1:0] in_letter      = '0;
  logic                          in_last        = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [pfdc_pkg::LETTER_W-1:0] out_letter;
  logic                          out_end_of_run;

  // predicted key square and pairing state
  logic [pfdc_pkg::LETTER_W-1:0] square_q [pfdc_pkg::CELLS];
  int                            cell_of_letter [pfdc_pkg::LETTERS];
  logic                          letter_in_square [pfdc_pkg::LETTERS];
  int                            filled_cells;
  logic [pfdc_pkg::LETTER_W-1:0] first_letter;
  logic                          first_pending;

  cipher_letter_t      letters_due[$];
  cipher_letter_t      due_head;

  int err_count    = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  playfair_digraph_cipher uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_letter      (in_letter),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_letter     (out_letter),
    .out_end_of_run (out_end_of_run)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // clamp codes past z, then j reads as i
  function automatic logic [pfdc_pkg::LETTER_W-1:0] fold_letter(
    input logic [pfdc_pkg::LETTER_W-1:0] raw);
    logic [pfdc_pkg::LETTER_W-1:0] c;
    c = raw;
    if (raw >= 5'd26) c = pfdc_pkg::CODE_Z;
    else if (raw == pfdc_pkg::CODE_J) c = pfdc_pkg::CODE_I;
    return c;
  endfunction

  function automatic void place_letter(input logic [pfdc_pkg::LETTER_W-1:0] c);
    if (filled_cells >= pfdc_pkg::CELLS || letter_in_square[c]) return;
    square_q[filled_cells] = c;
    cell_of_letter[c]      = filled_cells;
    letter_in_square[c]    = 1'b1;
    filled_cells++;
  endfunction

  // letters missing from the square sit in cell 0
  function automatic int cell_index_of(input logic [pfdc_pkg::LETTER_W-1:0] c);
    return letter_in_square[c] ? cell_of_letter[c] % pfdc_pkg::CELLS : 0;
  endfunction

  // unfilled cells read as a
  function automatic logic [pfdc_pkg::LETTER_W-1:0] letter_at(input int row, input int col);
    int idx;
    idx = row * SIDE + col;
    return (idx < filled_cells) ? square_q[idx] : 5'd0;
  endfunction

  // queue the two letters of one transformed pair
  function automatic void expect_pair(input logic [pfdc_pkg::LETTER_W-1:0] a,
                                      input logic [pfdc_pkg::LETTER_W-1:0] b,
                                      input logic dec);
    int pa, pb, ra, ca, rb, cb, step;
    cipher_letter_t x, y;
    step = dec ? SIDE - 1 : 1;
    pa = cell_index_of(a);
    pb = cell_index_of(b);
    ra = pa / SIDE;
    ca = pa % SIDE;
    rb = pb / SIDE;
    cb = pb % SIDE;
    x.eor = 1'b0;
    y.eor = 1'b0;
    if (ca == cb) begin
      x.letter = letter_at((ra + step) % SIDE, ca);
      y.letter = letter_at((rb + step) % SIDE, cb);
    end else if (ra == rb) begin
      x.letter = letter_at(ra, (ca + step) % SIDE);
      y.letter = letter_at(rb, (cb + step) % SIDE);
    end else begin
      x.letter = letter_at(ra, cb);
      y.letter = letter_at(rb, ca);
    end
    letters_due = {letters_due, x};
    letters_due = {letters_due, y};
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void predict_letters(input logic [pfdc_pkg::ACTION_W-1:0] act,
                                          input logic [pfdc_pkg::LETTER_W-1:0] raw,
                                          input logic lst);
    logic [pfdc_pkg::LETTER_W-1:0] c;
    int n0;
    c  = fold_letter(raw);
    n0 = letters_due.size();
    case (act)
      pfdc_pkg::ACT_CLEAR: begin
        foreach (letter_in_square[k]) letter_in_square[k] = 1'b0;
        filled_cells  = 0;
        first_letter  = '0;
        first_pending = 1'b0;
      end
      pfdc_pkg::ACT_KEY: place_letter(c);
      pfdc_pkg::ACT_FINISH: begin
        for (int k = 0; k < pfdc_pkg::LETTERS; k++) begin
          if (5'(k) != pfdc_pkg::CODE_J) place_letter(5'(k));
        end
      end
      pfdc_pkg::ACT_ENC: begin
        if (first_pending) begin
          first_pending = 1'b0;
          if (first_letter == c) begin
            expect_pair(first_letter, pfdc_pkg::CODE_Z, 1'b0);
            expect_pair(c, pfdc_pkg::CODE_Z, 1'b0);
          end else begin
            expect_pair(first_letter, c, 1'b0);
          end
        end else if (lst) begin
          expect_pair(c, pfdc_pkg::CODE_Z, 1'b0);
        end else begin
          first_letter  = c;
          first_pending = 1'b1;
        end
      end
      pfdc_pkg::ACT_DEC: begin
        if (first_pending) begin
          first_pending = 1'b0;
          expect_pair(first_letter, c, 1'b1);
        end else if (!lst) begin
          first_letter  = c;
          first_pending = 1'b1;
        end
      end
      default: ;
    endcase
    if (letters_due.size() > n0) letters_due[letters_due.size() - 1].eor = 1'b1;
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic send_action(input logic [pfdc_pkg::ACTION_W-1:0] act,
                             input logic [pfdc_pkg::LETTER_W-1:0] let_code,
                             input logic lst);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_letter <= let_code;
    in_last   <= lst;
    do @(posedge clk); while (!in_ready);
    predict_letters(act, let_code, lst);
    if (act <= pfdc_pkg::ACT_DEC) items_sent++;
  endtask

  task automatic set_traffic(input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (letters_due.size() == 0) begin
        report_mismatch($sformatf("unexpected letter %0d", out_letter));
      end else begin
        due_head = letters_due.pop_front();
        if (out_letter !== due_head.letter)
          report_mismatch($sformatf("letter %0d, want %0d", out_letter, due_head.letter));
        if (out_end_of_run !== due_head.eor)
          report_mismatch($sformatf("end_of_run %0b, want %0b", out_end_of_run,
                                    due_head.eor));
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // reserved action codes and encrypting against an empty square
  task automatic test_ignored_codes();
    send_action(3'd5, 5'd31, 1'b1);
    send_action(pfdc_pkg::ACT_ENC, 5'd0, 1'b0);
    send_action(pfdc_pkg::ACT_ENC, 5'd25, 1'b1);
    send_action(3'd6, 5'd9, 1'b0);
  endtask

  // key with j, a repeat, an out-of-range code, then use before finishing
  task automatic test_partial_key();
    send_action(pfdc_pkg::ACT_CLEAR, 5'd17, 1'b1);
    send_action(pfdc_pkg::ACT_KEY, pfdc_pkg::CODE_J, 1'b0);
    send_action(pfdc_pkg::ACT_KEY, pfdc_pkg::CODE_I, 1'b0);
    send_action(pfdc_pkg::ACT_KEY, 5'd31, 1'b0);
    send_action(pfdc_pkg::ACT_KEY, 5'd0, 1'b1);
    send_action(pfdc_pkg::ACT_ENC, 5'd3, 1'b0);
    send_action(pfdc_pkg::ACT_ENC, 5'd25, 1'b0);
  endtask

  // finish fills the square; further key items are dropped
  task automatic test_full_key();
    send_action(pfdc_pkg::ACT_FINISH, 5'd0, 1'b1);
    send_action(pfdc_pkg::ACT_FINISH, 5'd0, 1'b0);
    send_action(pfdc_pkg::ACT_KEY, 5'd4, 1'b0);
  endtask

  // doubled pair with j folded, odd last letter padding
  task automatic test_encrypt_rules();
    send_action(pfdc_pkg::ACT_ENC, pfdc_pkg::CODE_I, 1'b0);
    send_action(pfdc_pkg::ACT_ENC, pfdc_pkg::CODE_J, 1'b0);
    send_action(pfdc_pkg::ACT_ENC, 5'd17, 1'b1);
    send_action(pfdc_pkg::ACT_ENC, 5'd28, 1'b0);
    send_action(pfdc_pkg::ACT_ENC, 5'd6, 1'b0);
  endtask

  // mixed directions, odd trailing decrypt letter, clear dropping a held letter
  task automatic test_decrypt_rules();
    send_action(pfdc_pkg::ACT_ENC, 5'd1, 1'b0);
    send_action(pfdc_pkg::ACT_DEC, 5'd2, 1'b0);
    send_action(pfdc_pkg::ACT_DEC, 5'd3, 1'b1);
    send_action(pfdc_pkg::ACT_DEC, 5'd7, 1'b0);
    send_action(pfdc_pkg::ACT_DEC, 5'd12, 1'b1);
    send_action(pfdc_pkg::ACT_ENC, 5'd4, 1'b0);
    send_action(pfdc_pkg::ACT_CLEAR, 5'd0, 1'b0);
    send_action(3'd7, 5'd21, 1'b1);
    send_action(pfdc_pkg::ACT_DEC, 5'd5, 1'b0);
    send_action(pfdc_pkg::ACT_DEC, 5'd6, 1'b0);
  endtask

  function automatic logic [pfdc_pkg::LETTER_W-1:0] random_letter();
    if ($urandom_range(99) < 5) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(25));
  endfunction

  // random key sessions followed by messages, with some noise and broken streams
  task automatic run_key_sessions(input int target);
    int                            n_key, n_msg, len;
    logic [pfdc_pkg::ACTION_W-1:0] dir, act;
    logic [pfdc_pkg::LETTER_W-1:0] prev, cur;
    logic                          lst;
    while (items_sent < target) begin
      send_action(pfdc_pkg::ACT_CLEAR, random_letter(), 1'($urandom_range(1)));
      n_key = $urandom_range(0, 28);
      for (int k = 0; k < n_key && items_sent < target; k++)
        send_action(pfdc_pkg::ACT_KEY, random_letter(), ($urandom_range(99) < 5));
      if ($urandom_range(99) < 85)
        send_action(pfdc_pkg::ACT_FINISH, random_letter(), 1'($urandom_range(1)));
      n_msg = $urandom_range(1, 4);
      for (int m = 0; m < n_msg && items_sent < target; m++) begin
        dir  = $urandom_range(1) ? pfdc_pkg::ACT_ENC : pfdc_pkg::ACT_DEC;
        len  = $urandom_range(1, 9);
        prev = random_letter();
        for (int k = 0; k < len && items_sent < target; k++) begin
          cur = (k > 0 && $urandom_range(99) < 25) ? prev : random_letter();
          act = dir;
          if ($urandom_range(99) < 6)
            act = (dir == pfdc_pkg::ACT_ENC) ? pfdc_pkg::ACT_DEC : pfdc_pkg::ACT_ENC;
          lst = (k == len - 1) || ($urandom_range(99) < 4);
          if ($urandom_range(99) < 3) send_action(3'($urandom_range(5, 7)), random_letter(),
                                                  1'($urandom_range(1)));
          send_action(act, cur, lst);
          prev = cur;
        end
      end
    end
  endtask

  // random traffic in four phases with differing sender gaps and receiver stalls
  task automatic test_random_traffic();
    set_traffic(0, 0);
    run_key_sessions(items_sent + 86);
    set_traffic(46, 0);
    run_key_sessions(items_sent + 86);
    set_traffic(0, 46);
    run_key_sessions(items_sent + 86);
    set_traffic(19, 19);
    run_key_sessions(items_sent + 86);
  endtask

  initial begin
    foreach (letter_in_square[k]) letter_in_square[k] = 1'b0;
    foreach (cell_of_letter[k]) cell_of_letter[k] = 0;
    foreach (square_q[k]) square_q[k] = '0;
    filled_cells  = 0;
    first_letter  = '0;
    first_pending = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_codes();
    test_partial_key();
    test_full_key();
    test_encrypt_rules();
    test_decrypt_rules();
    test_random_traffic();

    // let the last results drain
    in_valid <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
